// ===== design/morse_symbol_bit_packer_core_defines.svh =====
`ifndef MORSE_SYMBOL_BIT_PACKER_CORE_DEFINES_SVH
`define MORSE_SYMBOL_BIT_PACKER_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define MSBP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("msbp check failed");

// next-cycle implication, checked out of reset
`define MSBP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("msbp check failed");

`endif

// ===== design/msbp_pkg.sv =====
package msbp_pkg;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } msbp_in_t;

  typedef struct packed {
    logic [7:0] packed_byte;
    logic       last_byte;
  } msbp_out_t;

  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [1:0] GAP_CODE     = 2'b10;
  localparam logic [1:0] SPACE_CODE   = 2'b11;
  localparam logic [5:0] NEWLINE_CODE = 6'b111111;

  // high nibble: symbol count, low nibble: dash bits, first symbol in the msb used
  function automatic logic [7:0] msbp_morse(input logic [4:0] idx);
    logic [7:0] pat;
    case (idx)
      5'd0:    pat = 8'h21;
      5'd1:    pat = 8'h48;
      5'd2:    pat = 8'h4A;
      5'd3:    pat = 8'h34;
      5'd4:    pat = 8'h10;
      5'd5:    pat = 8'h42;
      5'd6:    pat = 8'h36;
      5'd7:    pat = 8'h40;
      5'd8:    pat = 8'h20;
      5'd9:    pat = 8'h47;
      5'd10:   pat = 8'h35;
      5'd11:   pat = 8'h44;
      5'd12:   pat = 8'h23;
      5'd13:   pat = 8'h22;
      5'd14:   pat = 8'h37;
      5'd15:   pat = 8'h46;
      5'd16:   pat = 8'h4D;
      5'd17:   pat = 8'h32;
      5'd18:   pat = 8'h30;
      5'd19:   pat = 8'h11;
      5'd20:   pat = 8'h31;
      5'd21:   pat = 8'h41;
      5'd22:   pat = 8'h33;
      5'd23:   pat = 8'h49;
      5'd24:   pat = 8'h4B;
      5'd25:   pat = 8'h4C;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

endpackage

// ===== design/morse_symbol_bit_packer_core.sv =====
// accepted input beats are registered in in_r, then packed into the out_data buffer
// throughput: one input beat per cycle while each character yields at most one byte
// and out_stall is low; a character that yields two bytes stalls the input until the
// single output port has drained the two-entry result buffer to its last entry
// reset: synchronous active-low rst_n empties the input and result registers
// and clears the held symbol bits
module morse_symbol_bit_packer_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  msbp_pkg::msbp_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output msbp_pkg::msbp_out_t out_data
);
  import msbp_pkg::*;

  msbp_in_t    in_r;
  logic        in_vld_r, in_vld_nxt;
  logic [5:0]  pend_bits_r, pend_bits_nxt;
  logic [2:0]  pend_cnt_r, pend_cnt_nxt;
  logic [7:0]  byte0_r, byte0_nxt;
  logic [7:0]  byte1_r, byte1_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        last_r, last_nxt;

  logic        in_acc, out_acc, free, move;
  logic        letter;
  logic [4:0]  idx;
  logic [7:0]  pat;
  logic [7:0]  dash_exp;
  logic [9:0]  sym;
  logic [3:0]  sl;
  logic [15:0] acc;
  logic [4:0]  tot;
  logic [4:0]  sh;
  logic [15:0] word;
  logic [15:0] pad_mask;
  logic [5:0]  rem_mask;
  logic [1:0]  nb;

  assign out_acc  = out_valid && !out_stall;
  assign free     = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_acc);
  assign move     = in_vld_r && free;
  assign in_stall = in_vld_r && !free;
  assign in_acc   = in_valid && !in_stall;

  assign out_valid            = (cnt_r != 2'd0);
  assign out_data.packed_byte = byte0_r;
  assign out_data.last_byte   = last_r && (cnt_r == 2'd1);

  // symbol generation and packing
  always_comb begin
    letter = (in_r.text_byte[7:6] == 2'b01) && (in_r.text_byte[4:0] != 5'd0)
             && (in_r.text_byte[4:0] <= 5'd26);
    idx    = in_r.text_byte[4:0] - 5'd1;
    pat    = msbp_morse(idx);
    dash_exp = {1'b0, pat[3], 1'b0, pat[2], 1'b0, pat[1], 1'b0, pat[0]};
    if (letter) begin
      sym = {dash_exp, GAP_CODE};
      sl  = {pat[6:4], 1'b0} + 4'd2;
    end else if (in_r.text_byte == NEWLINE_CHAR) begin
      sym = {4'd0, NEWLINE_CODE};
      sl  = 4'd6;
    end else begin
      sym = {8'd0, SPACE_CODE};
      sl  = 4'd2;
    end
    acc      = ({10'd0, pend_bits_r} << sl) | {6'd0, sym};
    tot      = {2'd0, pend_cnt_r} + {1'b0, sl};
    sh       = 5'd16 - tot;
    word     = acc << sh;
    pad_mask = ~(16'hFFFF << sh);
    rem_mask = ~(6'h3F << tot[2:0]);
    nb       = tot[4:3];
    if (in_r.end_of_text && (tot[2:0] != 3'd0)) begin
      word = word | pad_mask;
      nb   = nb + 2'd1;
    end
  end

  always_comb begin
    in_vld_nxt    = in_vld_r;
    pend_bits_nxt = pend_bits_r;
    pend_cnt_nxt  = pend_cnt_r;
    byte0_nxt     = byte0_r;
    byte1_nxt     = byte1_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    if (out_acc) begin
      if (cnt_r == 2'd2) begin
        byte0_nxt = byte1_r;
        cnt_nxt   = 2'd1;
      end else begin
        cnt_nxt = 2'd0;
      end
    end
    if (move) begin
      byte0_nxt = word[15:8];
      byte1_nxt = word[7:0];
      cnt_nxt   = nb;
      last_nxt  = in_r.end_of_text;
      if (in_r.end_of_text) begin
        pend_bits_nxt = 6'd0;
        pend_cnt_nxt  = 3'd0;
      end else begin
        pend_bits_nxt = acc[5:0] & rem_mask;
        pend_cnt_nxt  = tot[2:0];
      end
      in_vld_nxt = 1'b0;
    end
    if (in_acc) begin
      in_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r    <= 1'b0;
      pend_bits_r <= 6'd0;
      pend_cnt_r  <= 3'd0;
      cnt_r       <= 2'd0;
      last_r      <= 1'b0;
    end else begin
      in_vld_r    <= in_vld_nxt;
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
      cnt_r       <= cnt_nxt;
      last_r      <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_r <= in_data;
    end
    byte0_r <= byte0_nxt;
    byte1_r <= byte1_nxt;
  end

endmodule

// ===== design/msbp_checker.sv =====
module msbp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input msbp_pkg::msbp_in_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input msbp_pkg::msbp_out_t out_data
);
  import msbp_pkg::*;
  `include "morse_symbol_bit_packer_core_defines.svh"

  // input only backs up behind a non-empty result buffer
  `MSBP_ASSERT_NOW(a_stall_needs_out, in_stall, out_valid)
  // nothing comes out on the first cycle after reset
  `MSBP_ASSERT_NOW(a_quiet_after_rst, 1'b1, $past(rst_n) || !out_valid)
  // a stalled output beat holds
  `MSBP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  // an empty result buffer never stalls the input
  `MSBP_ASSERT_NOW(a_no_stall_when_empty, !out_valid, !in_stall)
  // a stalled input beat holds
  `MSBP_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_data))

endmodule

bind morse_symbol_bit_packer_core msbp_checker u_msbp_checker (.*);

// ===== tb/sv/morse_packer_checker.sv =====
module morse_packer_checker
  import msbp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  msbp_in_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  msbp_out_t out_data,
  output int        mismatches,
  output int        waiting,
  output int        checked
);

  localparam logic [1:0] DOT_CODE  = 2'b00;
  localparam logic [1:0] DASH_CODE = 2'b01;

  string morse_code [26] = '{
    ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
    "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
    "..-", "...-", ".--", "-..-", "-.--", "--.."
  };

  msbp_out_t   predicted_bytes [$];
  logic [19:0] sym_acc;
  int          sym_len;
  int          produced;

  initial begin
    mismatches = 0;
    waiting    = 0;
    checked    = 0;
    sym_acc    = '0;
    sym_len    = 0;
  end

  function automatic void push_symbol(input logic [7:0] val, input int n);
    sym_acc = (sym_acc << n) | (20'(val) & ((20'd1 << n) - 20'd1));
    sym_len += n;
  endfunction

  function automatic void drain_bytes();
    msbp_out_t b;
    while (sym_len >= 8) begin
      b.packed_byte = 8'(sym_acc >> (sym_len - 8));
      b.last_byte   = 1'b0;
      predicted_bytes = {predicted_bytes, b};
      sym_len -= 8;
      sym_acc &= (20'd1 << sym_len) - 20'd1;
      produced++;
    end
  endfunction

  function automatic void encode_char(input msbp_in_t beat);
    string      pat;
    logic [7:0] ch;
    ch = beat.text_byte;
    produced = 0;
    if ((ch >= "A" && ch <= "Z") || (ch >= "a" && ch <= "z")) begin
      pat = morse_code[5'((ch | 8'h20) - "a")];
      for (int s = 0; s < pat.len(); s++) begin
        push_symbol(8'((pat[s] == "-") ? DASH_CODE : DOT_CODE), 2);
      end
      push_symbol(8'(GAP_CODE), 2);
    end else if (ch == NEWLINE_CHAR) begin
      push_symbol(8'(NEWLINE_CODE), 6);
    end else begin
      push_symbol(8'(SPACE_CODE), 2);
    end
    drain_bytes();
    if (beat.end_of_text) begin
      if (sym_len > 0) begin
        push_symbol(8'hFF, 8 - sym_len);
        drain_bytes();
      end
      if (produced > 0) begin
        predicted_bytes[predicted_bytes.size() - 1].last_byte = 1'b1;
      end
      sym_acc = '0;
      sym_len = 0;
    end
  endfunction

  always @(posedge clk) begin
    msbp_out_t want;
    if (!rst_n) begin
      predicted_bytes.delete();
      sym_acc = '0;
      sym_len = 0;
    end else begin
      if (in_valid && !in_stall) begin
        encode_char(in_data);
      end
      if (out_valid && !out_stall) begin
        checked++;
        if (predicted_bytes.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected beat, expected none, actual byte %h last %b",
                   $time, out_data.packed_byte, out_data.last_byte);
        end else begin
          want = predicted_bytes.pop_front();
          if (want.packed_byte !== out_data.packed_byte) begin
            mismatches++;
            $display("%0t: packed_byte expected %h actual %h",
                     $time, want.packed_byte, out_data.packed_byte);
          end
          if (want.last_byte !== out_data.last_byte) begin
            mismatches++;
            $display("%0t: last_byte expected %b actual %b",
                     $time, want.last_byte, out_data.last_byte);
          end
        end
      end
    end
    waiting = predicted_bytes.size();
  end

endmodule

// ===== tb/sv/tb_morse_symbol_bit_packer_core.sv =====
module tb_morse_symbol_bit_packer_core;
  import msbp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  msbp_in_t  in_data;
  logic      out_valid;
  logic      out_stall = 1'b0;
  msbp_out_t out_data;

  int mismatches;
  int waiting;
  int checked;
  int idle_pct = 0;
  int stall_pct = 0;
  int chars_sent = 0;
  int texts_ended = 0;
  int cycles = 0;

  morse_symbol_bit_packer_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  morse_packer_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .mismatches (mismatches),
    .waiting    (waiting),
    .checked    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still waiting", cycles, waiting);
      $display("tb_morse_symbol_bit_packer_core failed");
      $finish;
    end
  end

  task automatic send_char(input logic [7:0] ch, input logic eot);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data  <= '{text_byte: ch, end_of_text: eot};
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chars_sent++;
    if (eot) texts_ended++;
  endtask

  task automatic run_phase(input int count, input int idle, input int stall, input bit close);
    int         pick;
    logic [7:0] ch;
    logic       eot;
    idle_pct  = idle;
    stall_pct = stall;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        ch = "A" + 8'($urandom_range(25));
        if ($urandom_range(1)) ch = ch | 8'h20;
      end else if (pick < 62) begin
        ch = NEWLINE_CHAR;
      end else begin
        ch = 8'($urandom);
      end
      eot = ($urandom_range(11) == 0) || (close && i == count - 1);
      send_char(ch, eot);
    end
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: case mix, longest letters, newline, space-like bytes, end handling
    send_char("A", 1'b0);
    send_char("z", 1'b0);
    send_char("E", 1'b1);
    send_char(NEWLINE_CHAR, 1'b0);
    send_char("Q", 1'b1);
    send_char("E", 1'b0);
    send_char("E", 1'b1);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h80, 1'b0);
    send_char(8'h20, 1'b0);
    send_char(8'h40, 1'b0);
    send_char(8'h5B, 1'b0);
    send_char(8'h60, 1'b0);
    send_char(8'h7B, 1'b1);
    send_char("Z", 1'b0);
    send_char("a", 1'b0);
    send_char("M", 1'b0);
    send_char(NEWLINE_CHAR, 1'b0);
    send_char(NEWLINE_CHAR, 1'b1);
    send_char(8'h7F, 1'b1);
    send_char(8'h09, 1'b0);
    send_char(8'h0B, 1'b0);
    send_char(NEWLINE_CHAR, 1'b0);
    send_char("Y", 1'b1);

    run_phase(350, 0, 0, 1'b0);
    run_phase(350, 64, 0, 1'b0);
    run_phase(350, 0, 64, 1'b0);
    run_phase(350, 32, 32, 1'b1);

    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("sent %0d characters in %0d texts, compared %0d packed bytes",
             chars_sent, texts_ended, checked);
    $display("traffic mixes: free flow, sender gaps, receiver stalls, and both together");
    if (mismatches == 0) begin
      $display("tb_morse_symbol_bit_packer_core passed");
    end else begin
      $display("tb_morse_symbol_bit_packer_core failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/msbp_pkg.sv
design/morse_symbol_bit_packer_core.sv
design/msbp_checker.sv
tb/sv/morse_packer_checker.sv
tb/sv/tb_morse_symbol_bit_packer_core.sv
